// ===== hw/rtl/mc_pkg.sv =====
`default_nettype none

package mc_pkg;

    // Fixed field and store widths.
    localparam int CFG_W   = 11;
    localparam int PIX_W   = 8;
    localparam int OUT_W   = 18;
    localparam int XSUM_W  = 39;
    localparam int WSUM_W  = 28;
    localparam int APB_D_W = 32;
    localparam int ADDR_W  = 3;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 8;

    // Register reset values.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } mc_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DONE
    } mc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mc_div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mc_if.sv =====
`default_nettype none

interface mc_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [mc_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mc_result_if;
    logic                     valid;
    logic                     ready;
    logic [mc_pkg::OUT_W-1:0] centroid_x;
    logic [mc_pkg::OUT_W-1:0] centroid_y;
    logic                     empty_frame;

    modport source (output valid, output centroid_x, output centroid_y,
                    output empty_frame, input ready);
    modport sink   (input valid, input centroid_x, input centroid_y,
                    input empty_frame, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mc_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, with the quotient
// saturated to QUOT_W bits.
module mc_divider #(
    parameter int DIVIDEND_W = mc_pkg::XSUM_W + mc_pkg::FRACTION_BITS_DEF,
    parameter int DIVISOR_W  = mc_pkg::WSUM_W,
    parameter int QUOT_W     = mc_pkg::OUT_W
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DIVIDEND_W-1:0]  dividend,
    input  wire logic [DIVISOR_W-1:0]   divisor,
    output logic      [QUOT_W-1:0]      quotient,
    output mc_pkg::mc_div_status_t      status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]     quo_reg, quo_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        dvd_next     = dvd_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            dvd_next     = dividend;
            divisor_next = divisor;
            rem_next     = '0;
            quo_next     = '0;
            ovf_next     = 1'b0;
            cnt_next     = CNT_W'(DIVIDEND_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            // A bit pushed out of the top means the quotient is too large.
            ovf_next = ovf_reg | quo_reg[QUOT_W-1];
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        ovf_reg     <= ovf_next;
    end

    assign quotient    = ovf_reg ? {QUOT_W{1'b1}} : quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && $past(busy_reg)) |-> (rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("division finished without running");

endmodule

`default_nettype wire

// ===== hw/rtl/mask_centroid.sv =====
// After the transaction that carries the last pixel of a frame, the sequencer has the divider
// work out the column and then the row quotient and registers both into the output slot.
// Throughput: one pixel per cycle within a frame; after the last pixel the block takes no pixel
// while the shared bit-serial divider works and until the result has gone into the output slot.
// Reset: rst_n is asynchronous and active low; it clears counters, sums and the output slot
// and sets the frame size to 640 by 480.
`default_nettype none

module mask_centroid #(
    parameter int MAX_WIDTH     = mc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = mc_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = mc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mc_pkg::APB_D_W-1:0]  pwdata,
    output logic      [mc_pkg::APB_D_W-1:0]  prdata,
    output logic                             pready,
    mc_pixel_if.sink                         pixel,
    mc_result_if.source                      result
);

    // Counter widths follow the largest frame; the size compare is done wide enough for
    // both the register and the clamped limit.
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = (CW + 1 > mc_pkg::CFG_W) ? CW + 1 : mc_pkg::CFG_W;
    localparam int HW    = (RW + 1 > mc_pkg::CFG_W) ? RW + 1 : mc_pkg::CFG_W;
    localparam int DVD_W = mc_pkg::XSUM_W + FRACTION_BITS;
    localparam int PROD_W = CW + mc_pkg::PIX_W;
    localparam int PRODY_W = RW + mc_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers. The register is chosen by address bit 2, so
    // the width sits at byte address 0 and the height at byte address 4.
    // ------------------------------------------------------------------
    logic [mc_pkg::CFG_W-1:0] frame_width_reg;
    logic [mc_pkg::CFG_W-1:0] frame_height_reg;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= mc_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (mc_pkg::mc_reg_idx_t'(paddr[2]))
                mc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[mc_pkg::CFG_W-1:0];
                mc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[mc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mc_pkg::mc_reg_idx_t'(paddr[2]))
            mc_pkg::REG_FRAME_WIDTH:
                prdata = mc_pkg::APB_D_W'(frame_width_reg);
            mc_pkg::REG_FRAME_HEIGHT:
                prdata = mc_pkg::APB_D_W'(frame_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // A size of zero acts as one and a size beyond the maximum acts as the maximum.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(frame_width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (HW'(frame_height_reg) > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    // ------------------------------------------------------------------
    // Raster position and moment accumulators.
    // ------------------------------------------------------------------
    mc_pkg::mc_state_t state_reg, state_next;

    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [mc_pkg::XSUM_W-1:0]     xsum_reg, xsum_next;
    logic [mc_pkg::XSUM_W-1:0]     ysum_reg, ysum_next;
    logic [mc_pkg::WSUM_W-1:0]     wsum_reg, wsum_next;

    logic                          pix_acc;
    logic                          col_last;
    logic                          row_last;
    logic                          frame_end;
    logic [PROD_W-1:0]             x_prod;
    logic [PRODY_W-1:0]            y_prod;

    // Control decoded from the state.
    logic                          div_start;
    logic                          div_sel_y;
    logic                          load_qx;
    logic                          load_out;

    assign pix_acc   = pixel.valid && pixel.ready;
    // The comparisons use "at or beyond" so that a size reduced mid-frame still ends the row.
    assign col_last  = (WW'(col_reg) >= (w_eff - WW'(1)));
    assign row_last  = (HW'(row_reg) >= (h_eff - HW'(1)));
    assign frame_end = col_last && row_last;
    assign x_prod    = PROD_W'(col_reg) * PROD_W'(pixel.pixel_value);
    assign y_prod    = PRODY_W'(row_reg) * PRODY_W'(pixel.pixel_value);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        xsum_next = xsum_reg;
        ysum_next = ysum_reg;
        wsum_next = wsum_reg;
        if (pix_acc)
        begin
            xsum_next = xsum_reg + mc_pkg::XSUM_W'(x_prod);
            ysum_next = ysum_reg + mc_pkg::XSUM_W'(y_prod);
            wsum_next = wsum_reg + mc_pkg::WSUM_W'(pixel.pixel_value);
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        else if (load_out)
        begin
            // The sums of the finished frame have been used; start the next frame clean.
            xsum_next = '0;
            ysum_next = '0;
            wsum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            xsum_reg <= '0;
            ysum_reg <= '0;
            wsum_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            xsum_reg <= xsum_next;
            ysum_reg <= ysum_next;
            wsum_reg <= wsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider: the column quotient first, then the row quotient.
    // ------------------------------------------------------------------
    logic [DVD_W-1:0]           div_dividend;
    logic [mc_pkg::OUT_W-1:0]   div_quotient;
    mc_pkg::mc_div_status_t     div_stat;

    assign div_dividend = div_sel_y ? (DVD_W'(ysum_reg) << FRACTION_BITS)
                                    : (DVD_W'(xsum_reg) << FRACTION_BITS);

    mc_divider #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (mc_pkg::WSUM_W),
        .QUOT_W     (mc_pkg::OUT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (wsum_reg),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer. Pixels are taken only in the idle state. The result slot is
    // separate, so a new frame may start while the last result waits.
    // ------------------------------------------------------------------
    logic                      out_valid_reg, out_valid_next;
    logic [mc_pkg::OUT_W-1:0]  out_x_reg;
    logic [mc_pkg::OUT_W-1:0]  out_y_reg;
    logic                      out_empty_reg;
    logic [mc_pkg::OUT_W-1:0]  qx_reg;
    logic [mc_pkg::OUT_W-1:0]  qy_reg;
    logic                      slot_free;

    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mc_pkg::ST_IDLE:
                if (pix_acc && frame_end)
                    state_next = mc_pkg::ST_START;
            mc_pkg::ST_START:
                // An empty frame needs no division.
                state_next = (wsum_reg == '0) ? mc_pkg::ST_DONE : mc_pkg::ST_DIV_X;
            mc_pkg::ST_DIV_X:
                if (div_stat.done)
                    state_next = mc_pkg::ST_DIV_Y;
            mc_pkg::ST_DIV_Y:
                if (div_stat.done)
                    state_next = mc_pkg::ST_DONE;
            mc_pkg::ST_DONE:
                if (slot_free)
                    state_next = mc_pkg::ST_IDLE;
            default:
                state_next = mc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixel.ready = 1'b0;
        div_start   = 1'b0;
        div_sel_y   = 1'b0;
        load_qx     = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            mc_pkg::ST_IDLE:
                pixel.ready = 1'b1;
            mc_pkg::ST_START:
                div_start = (wsum_reg != '0);
            mc_pkg::ST_DIV_X:
            begin
                div_sel_y = 1'b1;
                div_start = div_stat.done;
                load_qx   = div_stat.done;
            end
            mc_pkg::ST_DIV_Y:
                div_sel_y = 1'b1;
            mc_pkg::ST_DONE:
                load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_qx)
            qx_reg <= div_quotient;
        if ((state_reg == mc_pkg::ST_DIV_Y) && div_stat.done)
            qy_reg <= div_quotient;
        if (load_out)
        begin
            out_empty_reg <= (wsum_reg == '0);
            out_x_reg     <= (wsum_reg == '0) ? '0 : qx_reg;
            out_y_reg     <= (wsum_reg == '0) ? '0 : qy_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.centroid_x  = out_x_reg;
    assign result.centroid_y  = out_y_reg;
    assign result.empty_frame = out_empty_reg;

    a_no_pixel_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |-> !div_stat.busy)
        else $error("pixel taken while the divider is busy");

    a_frame_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && frame_end) |=> (state_reg == mc_pkg::ST_START))
        else $error("frame end did not start the centroid sequence");

    a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("empty frame with a nonzero centroid");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (wsum_reg == '0 && xsum_reg == '0 && ysum_reg == '0))
        else $error("sums not cleared after a frame result");

endmodule

`default_nettype wire
